/* hw/rtl/tagged_record_packet_parser_defines.svh */
// Assertion macros shared by the tagged record packet parser checkers.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TAGGED_RECORD_PACKET_PARSER_DEFINES_SVH
`define TAGGED_RECORD_PACKET_PARSER_DEFINES_SVH

// same-cycle implication
`define TRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/trp_pkg.sv */
// Package for the tagged record packet parser: sizes, byte codes, kinds,
// status codes, parse phases and the structs passed between modules.
// No dependencies.
package trp_pkg;

  localparam int MAX_PACKET_BYTES = 65536;
  localparam int TRAILING_SLACK   = 3;
  localparam int NUM_KINDS        = 6;
  localparam int HDR_LEN          = 3;
  localparam int TAIL_LEN         = 4;

  localparam int POS_W      = $clog2(MAX_PACKET_BYTES + 1);
  localparam int FILL_W     = $clog2(TRAILING_SLACK + 1);
  localparam int LA_IDX_W   = (TRAILING_SLACK > 1) ? $clog2(TRAILING_SLACK) : 1;
  localparam int KIND_W     = 3;
  localparam int LEN_W      = 16;
  localparam int INTV_W     = 8;
  localparam int START_W    = 16;
  localparam int HDR_CNT_W  = 2;
  localparam int TAIL_CNT_W = 3;

  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'hFF;
  localparam logic [7:0] CHAR_O    = 8'h6F;
  localparam logic [7:0] CHAR_G    = 8'h67;
  localparam logic [7:0] CHAR_T    = 8'h74;
  localparam logic [7:0] CHAR_E    = 8'h65;
  localparam logic [7:0] CHAR_S    = 8'h73;
  localparam logic [7:0] CHAR_W    = 8'h77;
  localparam logic [7:0] CHAR_C    = 8'h63;
  localparam logic [7:0] CHAR_D    = 8'h64;
  localparam logic [7:0] CHAR_V    = 8'h76;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_OG = 3'd0;
  localparam kind_t KIND_TE = 3'd1;
  localparam kind_t KIND_SW = 3'd2;
  localparam kind_t KIND_CD = 3'd3;
  localparam kind_t KIND_WV = 3'd4;
  localparam kind_t KIND_WD = 3'd5;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_BAD_TAG    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_TAG1    = 4'd1,
    PH_TAG2    = 4'd2,
    PH_LENH    = 4'd3,
    PH_LENL    = 4'd4,
    PH_INTV    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_TAIL    = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    CTL_RUN    = 2'd0,
    CTL_FLUSH  = 2'd1,
    CTL_FINISH = 2'd2
  } ctl_state_t;

  typedef struct packed {
    logic        step;
    logic [7:0]  data;
    logic        region;
    logic        finish;
  } prs_req_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [INTV_W-1:0]  intv;
    logic [START_W-1:0] start;
  } rec_t;

endpackage

/* hw/rtl/trp_parser.sv */
// Byte parser for the tagged record packet parser: phase machine, position,
// per-kind record table and final status. Depends on trp_pkg.
module trp_parser import trp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  prs_req_t req,
  output rec_t     snap_recs [NUM_KINDS],
  output status_t  snap_status
);

  phase_t                  phase_r, phase_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [HDR_CNT_W-1:0]    hdr_r, hdr_nxt;
  logic [LEN_W-1:0]        skip_r, skip_nxt;
  kind_t                   kind_r, kind_nxt;
  logic [7:0]              len_hi_r, len_hi_nxt;
  logic [TAIL_CNT_W-1:0]   tail_r, tail_nxt;
  rec_t                    recs_r [NUM_KINDS];
  rec_t                    recs_nxt [NUM_KINDS];
  status_t                 err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      hdr_r    <= '0;
      skip_r   <= '0;
      kind_r   <= KIND_OG;
      len_hi_r <= '0;
      tail_r   <= '0;
      err_r    <= STATUS_OK;
      for (int i = 0; i < NUM_KINDS; i++) begin
        recs_r[i] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      hdr_r    <= hdr_nxt;
      skip_r   <= skip_nxt;
      kind_r   <= kind_nxt;
      len_hi_r <= len_hi_nxt;
      tail_r   <= tail_nxt;
      err_r    <= err_nxt;
      for (int i = 0; i < NUM_KINDS; i++) begin
        recs_r[i] <= recs_nxt[i];
      end
    end
  end

  always_comb begin
    logic                  fail_en;
    status_t               fail_code;
    logic                  tag_ok;
    logic [HDR_CNT_W-1:0]  hdr_inc;
    logic [TAIL_CNT_W-1:0] tail_inc;
    logic [LEN_W-1:0]      len_val;

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    hdr_nxt    = hdr_r;
    skip_nxt   = skip_r;
    kind_nxt   = kind_r;
    len_hi_nxt = len_hi_r;
    tail_nxt   = tail_r;
    err_nxt    = err_r;
    for (int i = 0; i < NUM_KINDS; i++) begin
      recs_nxt[i] = recs_r[i];
    end
    fail_en   = 1'b0;
    fail_code = STATUS_BAD_TAG;
    tag_ok    = 1'b0;
    hdr_inc   = hdr_r + ((req.data == HDR_BYTE) ? HDR_CNT_W'(1) : HDR_CNT_W'(0));
    tail_inc  = tail_r + ((req.data == TAIL_BYTE) ? TAIL_CNT_W'(1) : TAIL_CNT_W'(0));
    len_val   = {1'b0, len_hi_r, 7'b0} + {8'b0, req.data};

    if (req.finish) begin
      phase_nxt  = PH_HEADER;
      pos_nxt    = '0;
      hdr_nxt    = '0;
      skip_nxt   = '0;
      kind_nxt   = KIND_OG;
      len_hi_nxt = '0;
      tail_nxt   = '0;
      err_nxt    = STATUS_OK;
      for (int i = 0; i < NUM_KINDS; i++) begin
        recs_nxt[i] = '0;
      end
    end else if (req.step) begin
      if (phase_r != PH_DONE && pos_r >= POS_W'(MAX_PACKET_BYTES)) begin
        fail_en = 1'b1;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            hdr_nxt = hdr_inc;
            if (pos_r >= POS_W'(HDR_LEN - 1)) begin
              if (hdr_inc == HDR_CNT_W'(HDR_LEN)) begin
                phase_nxt = PH_TAG1;
              end else begin
                fail_en   = 1'b1;
                fail_code = STATUS_BAD_HEADER;
              end
            end
          end
          PH_TAG1: begin
            if (!req.region) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_TAG2;
              unique case (req.data)
                CHAR_O:  kind_nxt = KIND_OG;
                CHAR_T:  kind_nxt = KIND_TE;
                CHAR_S:  kind_nxt = KIND_SW;
                CHAR_C:  kind_nxt = KIND_CD;
                CHAR_W:  kind_nxt = KIND_WV;
                default: fail_en  = 1'b1;
              endcase
            end
          end
          PH_TAG2: begin
            unique case (kind_r)
              KIND_OG: tag_ok = (req.data == CHAR_G);
              KIND_TE: tag_ok = (req.data == CHAR_E);
              KIND_SW: tag_ok = (req.data == CHAR_W);
              KIND_CD: tag_ok = (req.data == CHAR_D);
              default: begin
                if (req.data == CHAR_V) begin
                  kind_nxt = KIND_WV;
                  tag_ok   = 1'b1;
                end else if (req.data == CHAR_D) begin
                  kind_nxt = KIND_WD;
                  tag_ok   = 1'b1;
                end
              end
            endcase
            if (tag_ok) begin
              phase_nxt = PH_LENH;
            end else begin
              fail_en = 1'b1;
            end
          end
          PH_LENH: begin
            len_hi_nxt = req.data;
            phase_nxt  = PH_LENL;
          end
          PH_LENL: begin
            recs_nxt[kind_r].len = len_val;
            skip_nxt  = len_val;
            phase_nxt = PH_INTV;
          end
          PH_INTV: begin
            recs_nxt[kind_r].intv  = req.data;
            recs_nxt[kind_r].start = pos_r[START_W-1:0] + START_W'(1);
            tail_nxt = '0;
            if (skip_r == '0) begin
              skip_nxt  = LEN_W'(TAIL_LEN);
              phase_nxt = PH_TAIL;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            skip_nxt = skip_r - LEN_W'(1);
            if (skip_r == LEN_W'(1)) begin
              skip_nxt  = LEN_W'(TAIL_LEN);
              phase_nxt = PH_TAIL;
            end
          end
          PH_TAIL: begin
            tail_nxt = tail_inc;
            skip_nxt = skip_r - LEN_W'(1);
            if (skip_r == LEN_W'(1)) begin
              if (tail_inc != TAIL_CNT_W'(TAIL_LEN)) begin
                recs_nxt[kind_r].start = '0;
              end
              phase_nxt = PH_TAG1;
            end
          end
          PH_DONE: begin
            phase_nxt = PH_DONE;
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
        if (pos_r < POS_W'(MAX_PACKET_BYTES)) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      if (fail_en) begin
        phase_nxt = PH_DONE;
        if (err_r == STATUS_OK) begin
          err_nxt = fail_code;
        end
      end
    end
  end

  always_comb begin
    snap_status = err_r;
    if (err_r == STATUS_OK) begin
      if (phase_r == PH_HEADER) begin
        snap_status = STATUS_BAD_HEADER;
      end else if (phase_r >= PH_TAG2 && phase_r <= PH_TAIL) begin
        snap_status = STATUS_BAD_TAG;
      end
    end
    for (int i = 0; i < NUM_KINDS; i++) begin
      snap_recs[i] = (snap_status == STATUS_OK) ? recs_r[i] : '0;
    end
  end

endmodule

/* hw/rtl/trp_result_buf.sv */
// Result buffer: holds the six records of a finished packet; sends them
// kind 0 first, one word per cycle unless stalled. Depends on trp_pkg.
module trp_result_buf import trp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  rec_t               snap_recs [NUM_KINDS],
  input  status_t            snap_status,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_record_kind,
  output logic [LEN_W-1:0]   out_payload_length,
  output logic [INTV_W-1:0]  out_interval_value,
  output logic [START_W-1:0] out_payload_start,
  output logic [1:0]         out_packet_status,
  output logic               out_final_result
);

  logic    busy_r, busy_nxt;
  kind_t   idx_r, idx_nxt;
  rec_t    ent_r [NUM_KINDS];
  rec_t    ent_nxt [NUM_KINDS];
  status_t status_r, status_nxt;
  logic    out_fire;
  logic    last_out;

  assign out_fire = busy_r && !out_stall;
  assign last_out = (idx_r == KIND_W'(NUM_KINDS - 1));
  assign ready    = !busy_r || (out_fire && last_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= KIND_OG;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    for (int i = 0; i < NUM_KINDS; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    for (int i = 0; i < NUM_KINDS; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    if (out_fire) begin
      if (last_out) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + KIND_W'(1);
        for (int i = 0; i < NUM_KINDS - 1; i++) begin
          ent_nxt[i] = ent_r[i+1];
        end
      end
    end
    if (load) begin
      busy_nxt   = 1'b1;
      idx_nxt    = KIND_OG;
      status_nxt = snap_status;
      for (int i = 0; i < NUM_KINDS; i++) begin
        ent_nxt[i] = snap_recs[i];
      end
    end
  end

  assign out_valid          = busy_r;
  assign out_record_kind    = idx_r;
  assign out_payload_length = ent_r[0].len;
  assign out_interval_value = ent_r[0].intv;
  assign out_payload_start  = ent_r[0].start;
  assign out_packet_status  = status_r;
  assign out_final_result   = last_out;

endmodule

/* hw/rtl/tagged_record_packet_parser.sv */
// Tagged record packet parser: takes one packet byte per word and, on the word
// marked end of packet, sends six result words (one per record kind, og first,
// wd last with out_final_result set). Inside a packet a byte is accepted every
// cycle. After the last byte of a packet in_stall stays high while the N (1 to
// 3) bytes still held in the three-byte lookahead line pass one by one through
// the single parse unit, and then until the record table is copied into the
// result buffer. The six results leave at one word per cycle while out_stall is
// low and the next packet streams in; if that packet ends before they are all
// taken, its copy waits for the buffer. Uses trp_pkg, trp_parser, trp_result_buf.
module tagged_record_packet_parser import trp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_packet_byte,
  input  logic               in_end_of_packet,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_record_kind,
  output logic [LEN_W-1:0]   out_payload_length,
  output logic [INTV_W-1:0]  out_interval_value,
  output logic [START_W-1:0] out_payload_start,
  output logic [1:0]         out_packet_status,
  output logic               out_final_result
);

  ctl_state_t        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        la_r [TRAILING_SLACK];
  logic [7:0]        la_nxt [TRAILING_SLACK];
  prs_req_t          req;
  rec_t              snap_recs [NUM_KINDS];
  status_t           snap_status;
  logic              rb_ready;
  logic              rb_load;
  logic              in_fire;

  assign in_stall = (state_r != CTL_RUN);
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_RUN;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TRAILING_SLACK; i++) begin
      la_r[i] <= la_nxt[i];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    for (int i = 0; i < TRAILING_SLACK; i++) begin
      la_nxt[i] = la_r[i];
    end
    req.step   = 1'b0;
    req.data   = la_r[0];
    req.region = 1'b0;
    req.finish = 1'b0;
    rb_load    = 1'b0;

    unique case (state_r)
      CTL_RUN: begin
        if (in_fire) begin
          if (fill_r == FILL_W'(TRAILING_SLACK)) begin
            req.step   = 1'b1;
            req.region = 1'b1;
            for (int i = 0; i < TRAILING_SLACK - 1; i++) begin
              la_nxt[i] = la_r[i+1];
            end
            la_nxt[TRAILING_SLACK-1] = in_packet_byte;
          end else begin
            la_nxt[fill_r[LA_IDX_W-1:0]] = in_packet_byte;
            fill_nxt = fill_r + FILL_W'(1);
          end
          if (in_end_of_packet) begin
            state_nxt = CTL_FLUSH;
          end
        end
      end
      CTL_FLUSH: begin
        req.step = 1'b1;
        for (int i = 0; i < TRAILING_SLACK - 1; i++) begin
          la_nxt[i] = la_r[i+1];
        end
        fill_nxt = fill_r - FILL_W'(1);
        if (fill_r == FILL_W'(1)) begin
          state_nxt = CTL_FINISH;
        end
      end
      CTL_FINISH: begin
        if (rb_ready) begin
          req.finish = 1'b1;
          rb_load    = 1'b1;
          fill_nxt   = '0;
          state_nxt  = CTL_RUN;
        end
      end
      default: begin
        state_nxt = CTL_RUN;
      end
    endcase
  end

  trp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .snap_recs   (snap_recs),
    .snap_status (snap_status)
  );

  trp_result_buf u_result_buf (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (rb_load),
    .snap_recs          (snap_recs),
    .snap_status        (snap_status),
    .ready              (rb_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_kind    (out_record_kind),
    .out_payload_length (out_payload_length),
    .out_interval_value (out_interval_value),
    .out_payload_start  (out_payload_start),
    .out_packet_status  (out_packet_status),
    .out_final_result   (out_final_result)
  );

endmodule

/* hw/rtl/trp_checker.sv */
// Port-level checker for the tagged record packet parser and its bind.
// Depends on trp_pkg and tagged_record_packet_parser_defines.svh.
`include "tagged_record_packet_parser_defines.svh"

module trp_checker import trp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_packet_byte,
  input logic               in_end_of_packet,
  input logic               out_valid,
  input logic               out_stall,
  input logic [KIND_W-1:0]  out_record_kind,
  input logic [LEN_W-1:0]   out_payload_length,
  input logic [INTV_W-1:0]  out_interval_value,
  input logic [START_W-1:0] out_payload_start,
  input logic [1:0]         out_packet_status,
  input logic               out_final_result
);

  `TRP_ASSERT_NOW(a_final_is_wd, out_valid && out_final_result, out_record_kind == KIND_WD, "final word is not kind wd")

  `TRP_ASSERT_NOW(a_error_zeroes, out_valid && (out_packet_status != STATUS_OK), (out_payload_length == '0) && (out_interval_value == '0) && (out_payload_start == '0), "error word carries nonzero fields")

  `TRP_ASSERT_NEXT(a_kind_step, out_valid && !out_stall && !out_final_result, out_valid && (out_record_kind == $past(out_record_kind) + KIND_W'(1)), "result kinds not consecutive")

  `TRP_ASSERT_NEXT(a_status_hold, out_valid && !out_stall && !out_final_result, out_packet_status == $past(out_packet_status), "status changed within a packet")

  `TRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_record_kind) && $stable(out_payload_start), "stalled result word changed")

endmodule

bind tagged_record_packet_parser trp_checker u_trp_checker (.*);

/* tb/tagged_record_packet_parser_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for tagged_record_packet_parser: feeds directed and random packet
// byte streams and checks the six result words of each packet against its own parser model.
// Depends on trp_pkg and the parser RTL only.
module tagged_record_packet_parser_tb;
  import trp_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_BYTES = 300;
  localparam int DRAIN_PACKET = 6;
  localparam int HOLD_AFTER   = 36;
  localparam int HOLD_CYCLES  = 600;
  localparam int MAX_REPORTS  = 10;
  localparam int END_CYCLES   = 20;
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef enum logic [1:0] {
    RX_FREE  = 2'd0,
    RX_LIGHT = 2'd1,
    RX_HEAVY = 2'd2
  } rx_mode_t;

  typedef struct {
    logic [7:0] value;
    logic       eop;
    logic       wait_drain;
  } byte_word_t;

  typedef struct packed {
    kind_t              kind;
    logic [LEN_W-1:0]   len;
    logic [INTV_W-1:0]  intv;
    logic [START_W-1:0] start;
    status_t            status;
    logic               last;
  } record_word_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_packet_byte = 8'h00;
  logic               in_end_of_packet = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KIND_W-1:0]  out_record_kind;
  logic [LEN_W-1:0]   out_payload_length;
  logic [INTV_W-1:0]  out_interval_value;
  logic [START_W-1:0] out_payload_start;
  logic [1:0]         out_packet_status;
  logic               out_final_result;

  tagged_record_packet_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_packet_byte     (in_packet_byte),
    .in_end_of_packet   (in_end_of_packet),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_record_kind    (out_record_kind),
    .out_payload_length (out_payload_length),
    .out_interval_value (out_interval_value),
    .out_payload_start  (out_payload_start),
    .out_packet_status  (out_packet_status),
    .out_final_result   (out_final_result)
  );

  byte_word_t   byte_words[$];
  logic [7:0]   pkt_bytes[$];
  record_word_t expected_records[$];
  record_word_t seen_word;
  record_word_t want_word;

  int taken_n = 0;
  int offered_n = 0;
  int results_seen = 0;
  int mismatch_n = 0;
  int packets_n = 0;
  int backpressure_n = 0;
  int cycle_n = 0;
  int status_count[3] = '{0, 0, 0};

  // parser model state
  phase_t             phase;
  int unsigned        byte_pos;
  int unsigned        hdr_seen;
  int unsigned        bytes_left;
  int unsigned        cur_kind;
  logic [7:0]         len_high;
  int unsigned        ff_seen;
  logic [LEN_W-1:0]   kind_len[NUM_KINDS];
  logic [INTV_W-1:0]  kind_intv[NUM_KINDS];
  logic [START_W-1:0] kind_start[NUM_KINDS];
  status_t            pkt_status;
  logic [7:0]         delay_line[TRAILING_SLACK];
  int unsigned        delay_fill;

  task automatic clear_parser();
    phase = PH_HEADER;
    byte_pos = 0;
    hdr_seen = 0;
    bytes_left = 0;
    cur_kind = 0;
    len_high = 8'h00;
    ff_seen = 0;
    pkt_status = STATUS_OK;
    delay_fill = 0;
    for (int i = 0; i < NUM_KINDS; i++) begin
      kind_len[i] = '0;
      kind_intv[i] = '0;
      kind_start[i] = '0;
    end
    for (int i = 0; i < TRAILING_SLACK; i++) begin
      delay_line[i] = 8'h00;
    end
  endtask

  task automatic abort_packet(status_t code);
    if (pkt_status == STATUS_OK) begin
      pkt_status = code;
    end
    phase = PH_DONE;
  endtask

  task automatic parse_byte(logic [7:0] b, logic may_open);
    int unsigned k;
    k = cur_kind % NUM_KINDS;
    if (phase != PH_DONE && byte_pos >= MAX_PACKET_BYTES) begin
      abort_packet(STATUS_BAD_TAG);
      return;
    end
    case (phase)
      PH_HEADER: begin
        if (b == HDR_BYTE) begin
          hdr_seen++;
        end
        if (byte_pos >= HDR_LEN - 1) begin
          if (hdr_seen == HDR_LEN) begin
            phase = PH_TAG1;
          end else begin
            abort_packet(STATUS_BAD_HEADER);
          end
        end
      end
      PH_TAG1: begin
        if (!may_open) begin
          phase = PH_DONE;
        end else begin
          phase = PH_TAG2;
          case (b)
            CHAR_O: cur_kind = KIND_OG;
            CHAR_T: cur_kind = KIND_TE;
            CHAR_S: cur_kind = KIND_SW;
            CHAR_C: cur_kind = KIND_CD;
            CHAR_W: cur_kind = KIND_WV;
            default: abort_packet(STATUS_BAD_TAG);
          endcase
        end
      end
      PH_TAG2: begin
        phase = PH_LENH;
        case (k)
          KIND_OG: if (b != CHAR_G) abort_packet(STATUS_BAD_TAG);
          KIND_TE: if (b != CHAR_E) abort_packet(STATUS_BAD_TAG);
          KIND_SW: if (b != CHAR_W) abort_packet(STATUS_BAD_TAG);
          KIND_CD: if (b != CHAR_D) abort_packet(STATUS_BAD_TAG);
          default: begin
            if (b == CHAR_V) begin
              cur_kind = KIND_WV;
            end else if (b == CHAR_D) begin
              cur_kind = KIND_WD;
            end else begin
              abort_packet(STATUS_BAD_TAG);
            end
          end
        endcase
      end
      PH_LENH: begin
        len_high = b;
        phase = PH_LENL;
      end
      PH_LENL: begin
        kind_len[k] = LEN_W'(int'(len_high) * 128 + int'(b));
        bytes_left = kind_len[k];
        phase = PH_INTV;
      end
      PH_INTV: begin
        kind_intv[k] = b;
        kind_start[k] = START_W'(byte_pos + 1);
        ff_seen = 0;
        if (bytes_left == 0) begin
          bytes_left = TAIL_LEN;
          phase = PH_TAIL;
        end else begin
          phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        bytes_left--;
        if (bytes_left == 0) begin
          bytes_left = TAIL_LEN;
          phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (b == TAIL_BYTE) begin
          ff_seen++;
        end
        bytes_left--;
        if (bytes_left == 0) begin
          if (ff_seen != TAIL_LEN) begin
            kind_start[k] = '0;
          end
          phase = PH_TAG1;
        end
      end
      default: phase = PH_DONE;
    endcase
    if (byte_pos < MAX_PACKET_BYTES) begin
      byte_pos++;
    end
  endtask

  task automatic take_byte(logic [7:0] b, logic is_last);
    record_word_t r;
    logic ok;
    if (delay_fill >= TRAILING_SLACK) begin
      parse_byte(delay_line[0], 1'b1);
      for (int i = 0; i < TRAILING_SLACK - 1; i++) begin
        delay_line[i] = delay_line[i + 1];
      end
      delay_line[TRAILING_SLACK - 1] = b;
    end else begin
      delay_line[delay_fill] = b;
      delay_fill++;
    end
    if (is_last) begin
      for (int i = 0; i < delay_fill; i++) begin
        parse_byte(delay_line[i], 1'b0);
      end
      if (pkt_status == STATUS_OK) begin
        if (phase == PH_HEADER) begin
          pkt_status = STATUS_BAD_HEADER;
        end else if (phase >= PH_TAG2 && phase <= PH_TAIL) begin
          pkt_status = STATUS_BAD_TAG;
        end
      end
      ok = (pkt_status == STATUS_OK);
      status_count[pkt_status]++;
      packets_n++;
      for (int i = 0; i < NUM_KINDS; i++) begin
        r.kind = kind_t'(i);
        r.len = ok ? kind_len[i] : '0;
        r.intv = ok ? kind_intv[i] : '0;
        r.start = ok ? kind_start[i] : '0;
        r.status = pkt_status;
        r.last = (i == NUM_KINDS - 1);
        expected_records.push_back(r);
      end
      clear_parser();
    end
  endtask

  function automatic logic [7:0] first_letter(kind_t kind);
    case (kind)
      KIND_OG: return CHAR_O;
      KIND_TE: return CHAR_T;
      KIND_SW: return CHAR_S;
      KIND_CD: return CHAR_C;
      default: return CHAR_W;
    endcase
  endfunction

  function automatic logic [7:0] second_letter(kind_t kind);
    case (kind)
      KIND_OG: return CHAR_G;
      KIND_TE: return CHAR_E;
      KIND_SW: return CHAR_W;
      KIND_CD: return CHAR_D;
      KIND_WV: return CHAR_V;
      default: return CHAR_D;
    endcase
  endfunction

  task automatic add_record(int unsigned kind, logic [7:0] len_h, logic [7:0] len_l,
                            bit bad_tail);
    int unsigned n;
    int unsigned bad_at;
    n = int'(len_h) * 128 + int'(len_l);
    bad_at = $urandom_range(0, TAIL_LEN - 1);
    pkt_bytes.push_back(first_letter(kind_t'(kind)));
    pkt_bytes.push_back(second_letter(kind_t'(kind)));
    pkt_bytes.push_back(len_h);
    pkt_bytes.push_back(len_l);
    pkt_bytes.push_back(8'($urandom));
    repeat (n) pkt_bytes.push_back(8'($urandom));
    for (int i = 0; i < TAIL_LEN; i++) begin
      pkt_bytes.push_back((bad_tail && i == bad_at) ? 8'($urandom_range(0, 254)) : TAIL_BYTE);
    end
  endtask

  task automatic emit_packet(bit wait_drain);
    foreach (pkt_bytes[i]) begin
      byte_words.push_back('{pkt_bytes[i], i == pkt_bytes.size() - 1, wait_drain && i == 0});
    end
    pkt_bytes.delete();
  endtask

  task automatic add_random_packet(bit wait_drain);
    int unsigned flavor;
    int unsigned nrec;
    int unsigned tag_at;
    int unsigned cut;
    bit bad_tail;
    flavor = $urandom_range(0, 99);
    if (flavor < 4) begin
      repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom));
    end else begin
      repeat (HDR_LEN) pkt_bytes.push_back(HDR_BYTE);
      if (flavor < 10) begin
        pkt_bytes[$urandom_range(0, HDR_LEN - 1)] = 8'($urandom);
      end
      nrec = $urandom_range(0, 3);
      for (int r = 0; r < nrec; r++) begin
        bad_tail = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 11) == 0) begin
          add_record($urandom_range(0, 5), 8'($urandom_range(0, 1)),
                     8'($urandom_range(0, 15)), bad_tail);
        end else begin
          add_record($urandom_range(0, 5), 8'h00, 8'($urandom_range(0, 6)), bad_tail);
        end
      end
      if (flavor >= 10 && flavor < 18) begin
        tag_at = pkt_bytes.size() + $urandom_range(0, 1);
        add_record($urandom_range(0, 5), 8'h00, 8'($urandom_range(0, 4)), 1'b0);
        pkt_bytes[tag_at] = 8'($urandom);
      end
      if (flavor >= 18 && flavor < 26) begin
        repeat ($urandom_range(4, 8)) pkt_bytes.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
      end
      if (flavor >= 26 && flavor < 36) begin
        cut = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
    end
    emit_packet(wait_drain);
  endtask

  task automatic build_stimulus();
    int first_random;
    int pkt_no;
    pkt_no = 0;
    // header cut short, header only, bad header
    pkt_bytes = '{HDR_BYTE};
    emit_packet(1'b0);
    pkt_bytes = '{HDR_BYTE, HDR_BYTE, HDR_BYTE};
    emit_packet(1'b0);
    pkt_bytes = '{HDR_BYTE, 8'h00, HDR_BYTE};
    emit_packet(1'b0);
    // zero-length wd record ending on the packet's last byte
    pkt_bytes = '{HDR_BYTE, HDR_BYTE, HDR_BYTE};
    add_record(KIND_WD, 8'h00, 8'h00, 1'b0);
    emit_packet(1'b0);
    // unknown second letter after w
    pkt_bytes = '{HDR_BYTE, HDR_BYTE, HDR_BYTE, CHAR_W, 8'hFF};
    emit_packet(1'b0);
    first_random = byte_words.size();
    while (byte_words.size() < first_random + RANDOM_BYTES || pkt_no <= DRAIN_PACKET) begin
      add_random_packet(pkt_no == DRAIN_PACKET);
      pkt_no++;
    end
  endtask

  task automatic note_mismatch(string what, record_word_t want, record_word_t got);
    mismatch_n++;
    if (mismatch_n <= MAX_REPORTS) begin
      $display("%0s at cycle %0d: expected kind %0d len %0d intv %0d start %0d status %0d last %0d",
               what, cycle_n, want.kind, want.len, want.intv, want.start, want.status, want.last);
      $display("  got kind %0d len %0d intv %0d start %0d status %0d last %0d",
               got.kind, got.len, got.intv, got.start, got.status, got.last);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_n,
               expected_records.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // driver: bursts of words with random gaps; hold a stalled word
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && taken_n == offered_n) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (taken_n < byte_words.size() &&
                 !(byte_words[taken_n].wait_drain && expected_records.size() != 0)) begin
      in_valid <= 1'b1;
      in_packet_byte <= byte_words[taken_n].value;
      in_end_of_packet <= byte_words[taken_n].eop;
      offered_n = taken_n;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: stall pattern in random stretches, one long hold-off
  rx_mode_t rx_mode = RX_FREE;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:  out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) begin
        backpressure_n++;
      end
      if (in_valid && !in_stall) begin
        take_byte(in_packet_byte, in_end_of_packet);
        taken_n++;
      end
      if (out_valid && !out_stall) begin
        seen_word.kind = out_record_kind;
        seen_word.len = out_payload_length;
        seen_word.intv = out_interval_value;
        seen_word.start = out_payload_start;
        seen_word.status = status_t'(out_packet_status);
        seen_word.last = out_final_result;
        results_seen++;
        if (expected_records.size() == 0) begin
          note_mismatch("Unexpected result", '0, seen_word);
        end else begin
          want_word = expected_records.pop_front();
          if (seen_word !== want_word) begin
            note_mismatch("Result mismatch", want_word, seen_word);
          end
        end
      end
    end
  end

  initial begin
    clear_parser();
    build_stimulus();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    while (taken_n < byte_words.size() || expected_records.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    $display("Parsed %0d packets in %0d bytes: %0d clean, %0d bad header, %0d bad tag/overflow",
             packets_n, taken_n, status_count[STATUS_OK], status_count[STATUS_BAD_HEADER],
             status_count[STATUS_BAD_TAG]);
    $display("Checked %0d result words; input held off for %0d cycles", results_seen,
             backpressure_n);
    if (mismatch_n == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
